FILE: hdl/dlt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dlt_pkg: shared types and constants of the DHCP lease table
// Message kinds, reply codes, register indexes, beat payloads and the
// sequencer states used by the lease table modules.
// ----------------------------------------------------------------------------
package dlt_pkg;

  localparam int unsigned MacW   = 48;
  localparam int unsigned IpW    = 32;
  localparam int unsigned CfgW   = 32;
  localparam int unsigned PoolSzW = 5;

  // A slot holding this address is free.
  localparam logic [MacW-1:0] MAC_FREE = {MacW{1'b1}};

  // Reset value of the lease time register (one day).
  localparam logic [IpW-1:0] LEASE_RESET = 32'd86400;

  typedef enum logic [1:0] {
    KIND_DISCOVER = 2'd0,
    KIND_REQUEST  = 2'd1,
    KIND_RELEASE  = 2'd2,
    KIND_OTHER    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REPLY_NONE  = 2'd0,
    REPLY_OFFER = 2'd1,
    REPLY_ACK   = 2'd2
  } reply_e;

  typedef enum logic [1:0] {
    CFG_POOL_START = 2'd0,
    CFG_POOL_SIZE  = 2'd1,
    CFG_LEASE      = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_e;

  // Input beat: one client message.
  typedef struct packed {
    kind_e           kind;
    logic [MacW-1:0] client_mac;
    logic            has_requested_ip;
    logic [IpW-1:0]  requested_ip;
  } req_t;

  // Output beat: the server's answer.
  typedef struct packed {
    reply_e         reply;
    logic [IpW-1:0] assigned_ip;
    logic [IpW-1:0] lease_time;
  } res_t;

endpackage
`default_nettype wire

FILE: hdl/dlt_slot_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dlt_slot_mem: client address store of the lease table
// One write port and one read port with a registered read. Each entry has a
// valid bit cleared at reset; an entry not yet written reads as free.
// ----------------------------------------------------------------------------
module dlt_slot_mem
  import dlt_pkg::*;
#(
  parameter int unsigned Depth = 16,
  parameter int unsigned IdxW  = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            rd_en_i,
  input  wire logic [IdxW-1:0] rd_addr_i,
  output logic      [MacW-1:0] rd_data_o,
  input  wire logic            wr_en_i,
  input  wire logic [IdxW-1:0] wr_addr_i,
  input  wire logic [MacW-1:0] wr_data_i
);

  logic [MacW-1:0] mem_q [Depth];
  logic [Depth-1:0] vld_q;
  logic [MacW-1:0] rd_data_q;
  logic            rd_vld_q;

  // Storage array and registered read data.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Per-entry valid bits and the valid flag of the read beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // An entry never written reads as the free marker.
  assign rd_data_o = rd_vld_q ? rd_data_q : MAC_FREE;

endmodule
`default_nettype wire

FILE: hdl/dlt_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dlt_seq: message sequencer of the lease table
// Scans the slots in use one read a cycle, noting the first slot holding the
// client and the first free slot, then decides the reply and writes back.
// ----------------------------------------------------------------------------
module dlt_seq
  import dlt_pkg::*;
#(
  parameter int unsigned MaxClients = 16,
  parameter int unsigned IdxW       = 4,
  parameter int unsigned CntW       = 5
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Request side
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire req_t               in_req_i,
  // Configuration
  input  wire logic [IpW-1:0]     pool_start_i,
  input  wire logic [PoolSzW-1:0] pool_size_i,
  input  wire logic [IpW-1:0]     lease_i,
  // Result side
  input  wire logic               res_free_i,
  output logic                    res_load_o,
  output res_t                    res_o,
  // Slot memory
  output logic                    rd_en_o,
  output logic [IdxW-1:0]         rd_addr_o,
  input  wire logic [MacW-1:0]    rd_data_i,
  output logic                    wr_en_o,
  output logic [IdxW-1:0]         wr_addr_o,
  output logic [MacW-1:0]         wr_data_o
);

  state_e state_q, state_d;
  req_t   req_q;

  logic [CntW-1:0] n_q, n_d;
  logic [CntW-1:0] ri_q, ri_d;
  logic            chk_vld_q;
  logic [IdxW-1:0] chk_idx_q;

  logic            hit_q, hit_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d;
  logic            free_q, free_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;

  logic            accept;
  logic            sel_ok;
  logic [IdxW-1:0] sel_idx;
  logic [IpW-1:0]  sel_ip;
  reply_e          reply;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Number of slots in use, capped at the table depth.
  always_comb begin
    if (32'(pool_size_i) > 32'(MaxClients)) begin
      n_d = CntW'(MaxClients);
    end else begin
      n_d = CntW'(pool_size_i);
    end
  end

  // Read issue during the scan.
  assign rd_en_o   = (state_q == ST_SCAN) && (ri_q < n_q);
  assign rd_addr_o = ri_q[IdxW-1:0];

  // First match and first free slot, checked one read beat behind the issue.
  always_comb begin
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    ri_d       = ri_q;
    if (accept) begin
      hit_d  = 1'b0;
      free_d = 1'b0;
      ri_d   = '0;
    end else begin
      if (rd_en_o) begin
        ri_d = ri_q + CntW'(1);
      end
      if (chk_vld_q) begin
        if (!hit_q && (rd_data_i == req_q.client_mac)) begin
          hit_d     = 1'b1;
          hit_idx_d = chk_idx_q;
        end
        if (!free_q && (rd_data_i == MAC_FREE)) begin
          free_d     = 1'b1;
          free_idx_d = chk_idx_q;
        end
      end
    end
  end

  // Reply decision and write-back.
  always_comb begin
    reply     = REPLY_NONE;
    sel_ok    = hit_q;
    sel_idx   = hit_idx_q;
    wr_en_o   = 1'b0;
    wr_addr_o = hit_idx_q;
    wr_data_o = MAC_FREE;
    if (!hit_q && (req_q.kind == KIND_DISCOVER)) begin
      sel_ok  = free_q;
      sel_idx = free_idx_q;
    end
    sel_ip = pool_start_i + IpW'(sel_idx);

    case (req_q.kind)
      KIND_DISCOVER: begin
        if (sel_ok) begin
          reply = REPLY_OFFER;
          if (!hit_q) begin
            wr_en_o   = 1'b1;
            wr_addr_o = free_idx_q;
            wr_data_o = req_q.client_mac;
          end
        end
      end
      KIND_REQUEST: begin
        if (hit_q && req_q.has_requested_ip) begin
          if (sel_ip == req_q.requested_ip) begin
            reply = REPLY_ACK;
          end else begin
            wr_en_o = 1'b1;
          end
        end
      end
      KIND_RELEASE: begin
        wr_en_o = hit_q;
      end
      default: begin
        reply = REPLY_NONE;
      end
    endcase

    // Only commit once the result can be stored.
    if (!res_load_o) begin
      wr_en_o = 1'b0;
    end

    res_o.reply       = reply;
    res_o.assigned_ip = (reply != REPLY_NONE) ? sel_ip : '0;
    res_o.lease_time  = (reply != REPLY_NONE) ? lease_i : '0;
  end

  assign res_load_o = (state_q == ST_DECIDE) && res_free_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!rd_en_o && !chk_vld_q) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (res_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      chk_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      ri_q      <= '0;
    end else begin
      state_q   <= state_d;
      chk_vld_q <= rd_en_o;
      hit_q     <= hit_d;
      free_q    <= free_d;
      ri_q      <= ri_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
      n_q   <= n_d;
    end
    chk_idx_q  <= rd_addr_o;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
  end

endmodule
`default_nettype wire

FILE: hdl/dhcp_lease_table_core.sv
`default_nettype none
// Operation: an accepted beat is checked against each slot in use, one slot
// read a cycle (none for an empty pool), then its result is loaded into the
// output register once that is free. Flow: one message at a time; the next
// beat is taken only after the last result has been loaded.
// Reset: every slot reads as free at once (per-entry valid bits); the control
// and config registers reset; a new beat is taken while a result still waits.
// ----------------------------------------------------------------------------
// dhcp_lease_table_core: address pool of a simple DHCP server
// Keeps one client hardware address per leasable address, answers discover
// and request messages with offers and acknowledges, and frees slots.
// ----------------------------------------------------------------------------
module dhcp_lease_table_core
  import dlt_pkg::*;
#(
  parameter int unsigned MAX_CLIENTS = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  // Configuration write port
  input  wire logic            cfg_we_i,
  input  wire logic [1:0]      cfg_idx_i,
  input  wire logic [CfgW-1:0] cfg_wdata_i,
  // Message input
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire req_t            in_req_i,
  // Reply output
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output res_t                 out_res_o
);

  localparam int unsigned IdxW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int unsigned CntW = $clog2(MAX_CLIENTS + 1);

  logic [IpW-1:0]     pool_start_q;
  logic [PoolSzW-1:0] pool_size_q;
  logic [IpW-1:0]     lease_q;

  logic            out_valid_q;
  res_t            out_res_q;
  logic            res_free;
  logic            res_load;
  res_t            res;

  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic [MacW-1:0] rd_data;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [MacW-1:0] wr_data;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_start_q <= '0;
      pool_size_q  <= '0;
      lease_q      <= LEASE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_POOL_START: pool_start_q <= cfg_wdata_i;
        CFG_POOL_SIZE:  pool_size_q  <= cfg_wdata_i[PoolSzW-1:0];
        CFG_LEASE:      lease_q      <= cfg_wdata_i;
        default: begin
          pool_start_q <= pool_start_q;
        end
      endcase
    end
  end

  dlt_seq #(
    .MaxClients (MAX_CLIENTS),
    .IdxW       (IdxW),
    .CntW       (CntW)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_req_i     (in_req_i),
    .pool_start_i (pool_start_q),
    .pool_size_i  (pool_size_q),
    .lease_i      (lease_q),
    .res_free_i   (res_free),
    .res_load_o   (res_load),
    .res_o        (res),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data)
  );

  dlt_slot_mem #(
    .Depth (MAX_CLIENTS),
    .IdxW  (IdxW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // Output register: free when empty or being taken this cycle.
  assign res_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule
`default_nettype wire

FILE: bench/tb_dhcp_lease_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_dhcp_lease_table_core: self-checking bench of the DHCP lease table core
// Client messages are offered in random bursts and answers are taken under a
// changing stall pattern. A shadow lease table in the bench serves every
// accepted message, and each returned beat is checked field by field against
// the oldest predicted answer. The bench walks through several pool settings,
// including empty, oversized, shrunk and wrapping pools.
// ----------------------------------------------------------------------------
module tb_dhcp_lease_table_core;
  import dlt_pkg::*;

  localparam int unsigned SLOTS        = 16;
  localparam int          DRAIN_CYCLES = SLOTS + 6;
  localparam int          QUIET_LIMIT  = 4000;
  localparam int          HOLD_AT      = 120;
  localparam int          HOLD_LONG    = 500;

  // Fixed client addresses used by the directed part.
  localparam logic [MacW-1:0] MAC_A = 48'h02_00_5E_00_00_0A;
  localparam logic [MacW-1:0] MAC_B = 48'h80_00_00_00_00_0B;
  localparam logic [MacW-1:0] MAC_C = 48'h7F_FF_FF_FF_FF_FE;
  localparam logic [MacW-1:0] MAC_D = 48'h00_11_22_33_44_55;
  localparam logic [MacW-1:0] MAC_E = 48'hAA_55_AA_55_AA_55;
  localparam logic [MacW-1:0] MAC_F = 48'h01_23_45_67_89_AB;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            cfg_we_i    = 1'b0;
  logic [1:0]      cfg_idx_i   = CFG_POOL_START;
  logic [CfgW-1:0] cfg_wdata_i = '0;
  logic            in_valid_i  = 1'b0;
  logic            in_ready_o;
  req_t            in_req_i    = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  res_t            out_res_o;

  // Shadow copy of the lease table and its registers.
  logic [MacW-1:0]    slot_mac [SLOTS];
  logic [IpW-1:0]     pool_start;
  logic [PoolSzW-1:0] pool_size;
  logic [IpW-1:0]     lease_secs;

  // Messages waiting to be offered, and answers still to come back.
  req_t msg_q[$];
  res_t reply_q[$];

  logic [MacW-1:0] client_macs [24];

  int   bad_count    = 0;
  int   burst_left   = 0;
  int   gap_left     = 0;
  int   hold_left    = 0;
  int   rx_mode      = 0;
  int   rx_mode_left = 0;
  int   replies_seen = 0;
  int   quiet_cycles = 0;
  res_t want_res;

  dhcp_lease_table_core #(
    .MAX_CLIENTS(SLOTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (out_res_o)
  );

  always #5 clk_i = ~clk_i;

  // Index of the first slot in use holding mac, or -1 when there is none.
  function automatic int find_slot(logic [MacW-1:0] mac);
    int n;
    int i;
    n = (pool_size > SLOTS) ? SLOTS : int'(pool_size);
    for (i = 0; i < n; i++) begin
      if (slot_mac[i] == mac) return i;
    end
    return -1;
  endfunction

  // Address of a slot; the sum wraps at 32 bits.
  function automatic logic [IpW-1:0] slot_addr(int slot);
    return pool_start + slot[IpW-1:0];
  endfunction

  // Serves one message against the shadow table and returns the answer.
  function automatic res_t serve_message(req_t m);
    res_t r;
    int   slot;
    r       = '0;
    r.reply = REPLY_NONE;
    slot    = find_slot(m.client_mac);
    case (m.kind)
      KIND_DISCOVER: begin
        if (slot < 0) begin
          slot = find_slot(MAC_FREE);
          if (slot >= 0) slot_mac[slot] = m.client_mac;
        end
        if (slot >= 0) r.reply = REPLY_OFFER;
      end
      KIND_REQUEST: begin
        if (slot >= 0 && m.has_requested_ip) begin
          if (slot_addr(slot) == m.requested_ip) r.reply = REPLY_ACK;
          else slot_mac[slot] = MAC_FREE;
        end
      end
      KIND_RELEASE: begin
        if (slot >= 0) slot_mac[slot] = MAC_FREE;
      end
      default: begin
      end
    endcase
    if (r.reply != REPLY_NONE) begin
      r.assigned_ip = slot_addr(slot);
      r.lease_time  = lease_secs;
    end
    return r;
  endfunction

  function automatic req_t msg(kind_e k, logic [MacW-1:0] mac, logic has_ip,
                               logic [IpW-1:0] ip);
    req_t m;
    m.kind             = k;
    m.client_mac       = mac;
    m.has_requested_ip = has_ip;
    m.requested_ip     = ip;
    return m;
  endfunction

  // Waits until every message has been answered and the core has gone quiet.
  task automatic settle();
    while (msg_q.size() != 0 || reply_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Register writes are only issued once the core is idle.
  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] value);
    settle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_POOL_START: pool_start = value;
      CFG_POOL_SIZE:  pool_size  = value[PoolSzW-1:0];
      CFG_LEASE:      lease_secs = value;
      default: begin
      end
    endcase
  endtask

  // Random traffic, mostly from a small set of clients so that discovers,
  // requests and releases meet the same slots. The shadow table is consulted
  // so that most requests name the client's own address.
  task automatic run_phase(int count);
    req_t        m;
    int          n_eff;
    int          pick;
    int          slot;
    int          k;
    logic [63:0] wide;
    n_eff = (pool_size > SLOTS) ? SLOTS : int'(pool_size);
    for (k = 0; k < count; k++) begin
      while (msg_q.size() >= 3) @(negedge clk_i);
      pick = $urandom_range(0, 99);
      if (pick < 40) m.kind = KIND_DISCOVER;
      else if (pick < 75) m.kind = KIND_REQUEST;
      else if (pick < 90) m.kind = KIND_RELEASE;
      else m.kind = KIND_OTHER;
      pick = $urandom_range(0, 99);
      wide = {$urandom(), $urandom()};
      if (pick < 3) m.client_mac = MAC_FREE;
      else if (pick < 80) m.client_mac = client_macs[$urandom_range(0, n_eff + 3)];
      else m.client_mac = wide[MacW-1:0];
      if (m.kind == KIND_REQUEST) m.has_requested_ip = ($urandom_range(0, 9) != 0);
      else m.has_requested_ip = 1'($urandom_range(0, 1));
      slot = find_slot(m.client_mac);
      pick = $urandom_range(0, 99);
      if (m.kind == KIND_REQUEST && slot >= 0 && pick < 75) m.requested_ip = slot_addr(slot);
      else if (pick < 90) m.requested_ip = slot_addr($urandom_range(0, 17));
      else m.requested_ip = $urandom();
      msg_q.push_back(m);
    end
  endtask

  // Reports a bad answer; only the first few are printed in full.
  task automatic note_bad(string what, res_t want, res_t got);
    bad_count++;
    if (bad_count <= 10) begin
      $display("%s: expected reply %0d ip %h lease %h, got reply %0d ip %h lease %h",
               what, want.reply, want.assigned_ip, want.lease_time,
               got.reply, got.assigned_ip, got.lease_time);
    end
  endtask

  // Driver: offers queued messages in bursts separated by random gaps.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        reply_q.push_back(serve_message(in_req_i));
        void'(msg_q.pop_front());
      end
      if (in_valid_i && !in_ready_o) begin
        // The offered beat stays as it is until the core takes it.
      end else if (gap_left != 0) begin
        gap_left   <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (msg_q.size() != 0) begin
        in_valid_i <= 1'b1;
        in_req_i   <= msg_q[0];
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 16);
          case ($urandom_range(0, 2))
            0:       gap_left <= 0;
            1:       gap_left <= $urandom_range(1, 5);
            default: gap_left <= $urandom_range(6, 40);
          endcase
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: checks each answer beat and stalls the output on its own
  // pattern, with one long hold-off so that the core backs up its input.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (reply_q.size() == 0) begin
          note_bad("answer with no message pending", '0, out_res_o);
        end else begin
          want_res = reply_q.pop_front();
          if (out_res_o.reply !== want_res.reply ||
              out_res_o.assigned_ip !== want_res.assigned_ip ||
              out_res_o.lease_time !== want_res.lease_time) begin
            note_bad("answer mismatch", want_res, out_res_o);
          end
        end
        replies_seen <= replies_seen + 1;
      end
      if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else if (out_valid_o && out_ready_i &&
                   (replies_seen == HOLD_AT || $urandom_range(0, 399) == 0)) begin
        hold_left   <= (replies_seen == HOLD_AT) ? HOLD_LONG : $urandom_range(100, 300);
        out_ready_i <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode      <= $urandom_range(0, 2);
          rx_mode_left <= $urandom_range(10, 80);
        end else begin
          rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Watchdog: ends the run when no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("dhcp_lease_table_core test failed");
      $finish;
    end
  end

  // Stimulus sequence: reset, directed messages, then random phases.
  initial begin
    int i;
    for (i = 0; i < SLOTS; i++) slot_mac[i] = MAC_FREE;
    pool_start = '0;
    pool_size  = '0;
    lease_secs = LEASE_RESET;
    for (i = 0; i < 24; i++) client_macs[i] = {16'($urandom_range(0, 16'hFFFF)), $urandom()};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty pool straight after reset: nothing is ever offered.
    msg_q.push_back(msg(KIND_DISCOVER, MAC_A, 1'b0, '0));
    msg_q.push_back(msg(KIND_REQUEST, MAC_A, 1'b1, '0));

    // Three slots whose addresses wrap past the top of the address space.
    write_reg(CFG_POOL_START, 32'hFFFF_FFFE);
    write_reg(CFG_POOL_SIZE, 3);
    write_reg(CFG_LEASE, '1);
    msg_q.push_back(msg(KIND_DISCOVER, MAC_A, 1'b0, '0));
    msg_q.push_back(msg(KIND_DISCOVER, MAC_A, 1'b1, '1));
    msg_q.push_back(msg(KIND_DISCOVER, MAC_B, 1'b0, '0));
    msg_q.push_back(msg(KIND_DISCOVER, MAC_C, 1'b0, '0));
    // Pool full for a new client.
    msg_q.push_back(msg(KIND_DISCOVER, MAC_D, 1'b0, '0));
    msg_q.push_back(msg(KIND_REQUEST, MAC_A, 1'b1, 32'hFFFF_FFFE));
    // Requested address missing, then a wrong one that frees the slot.
    msg_q.push_back(msg(KIND_REQUEST, MAC_A, 1'b0, 32'hFFFF_FFFE));
    msg_q.push_back(msg(KIND_REQUEST, MAC_B, 1'b1, 32'h0000_0005));
    msg_q.push_back(msg(KIND_DISCOVER, MAC_D, 1'b0, '0));
    msg_q.push_back(msg(KIND_RELEASE, MAC_C, 1'b0, '0));
    // Unknown client asking and releasing.
    msg_q.push_back(msg(KIND_RELEASE, MAC_E, 1'b1, '1));
    msg_q.push_back(msg(KIND_REQUEST, MAC_E, 1'b1, 32'hFFFF_FFFE));
    msg_q.push_back(msg(KIND_OTHER, MAC_FREE, 1'b1, '1));
    // A client whose address is all ones takes the first free slot as its own.
    msg_q.push_back(msg(KIND_DISCOVER, MAC_FREE, 1'b0, '0));
    msg_q.push_back(msg(KIND_REQUEST, MAC_FREE, 1'b1, 32'h0000_0000));
    msg_q.push_back(msg(KIND_RELEASE, MAC_FREE, 1'b0, '0));
    msg_q.push_back(msg(KIND_OTHER, '0, 1'b0, '0));
    msg_q.push_back(msg(KIND_DISCOVER, '0, 1'b0, '0));

    // Shrunk pool hides the slot of the last client but keeps it.
    write_reg(CFG_POOL_SIZE, 1);
    msg_q.push_back(msg(KIND_DISCOVER, MAC_D, 1'b0, '0));
    msg_q.push_back(msg(KIND_REQUEST, MAC_A, 1'b1, 32'hFFFF_FFFE));
    msg_q.push_back(msg(KIND_REQUEST, MAC_D, 1'b1, 32'hFFFF_FFFF));

    // Oversized pool counts as the full table; the hidden slot is back.
    write_reg(CFG_POOL_SIZE, 31);
    msg_q.push_back(msg(KIND_REQUEST, MAC_D, 1'b1, 32'hFFFF_FFFF));
    msg_q.push_back(msg(KIND_DISCOVER, MAC_F, 1'b0, '0));

    // Random phases over a range of pool settings.
    write_reg(CFG_POOL_START, $urandom());
    write_reg(CFG_POOL_SIZE, 4);
    write_reg(CFG_LEASE, $urandom());
    run_phase(200);
    write_reg(CFG_POOL_START, '0);
    write_reg(CFG_POOL_SIZE, 16);
    write_reg(CFG_LEASE, '0);
    run_phase(220);
    write_reg(CFG_POOL_START, 32'hFFFF_FFF8);
    write_reg(CFG_POOL_SIZE, 31);
    write_reg(CFG_LEASE, '1);
    run_phase(220);
    write_reg(CFG_POOL_SIZE, 2);
    run_phase(150);
    write_reg(CFG_POOL_SIZE, 0);
    write_reg(CFG_LEASE, LEASE_RESET);
    run_phase(60);
    write_reg(CFG_POOL_START, $urandom());
    write_reg(CFG_POOL_SIZE, 17);
    run_phase(220);
    write_reg(CFG_POOL_SIZE, 8);
    write_reg(CFG_LEASE, $urandom());
    run_phase(220);
    write_reg(CFG_POOL_START, $urandom());
    write_reg(CFG_POOL_SIZE, $urandom_range(1, 31));
    write_reg(CFG_LEASE, $urandom());
    run_phase(250);

    settle();
    if (bad_count == 0) begin
      $display("dhcp_lease_table_core test passed");
    end else begin
      $display("dhcp_lease_table_core test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
